FILE: rtl/ecd_pkg.sv
// Shared types and constants for the two-disc elastic collision core.
// Holds the request/result structs and the fixed-point widths of the datapath.
// No dependencies.
package ecd_pkg;

	// binary point of the unit normal (Q.28)
	localparam int unsigned NORM_BITS  = 28;
	// restoring square root: one result bit per stage
	localparam int unsigned SQRT_STEPS = 32;
	// normal divider: (|d| << 28 + len/2) / len
	localparam int unsigned NNUM_W     = 60;
	localparam int unsigned NDEN_W     = 32;
	localparam int unsigned NQ_W       = 29;
	// momentum divider: (|num| + sum/2) / sum
	localparam int unsigned MNUM_W     = 52;
	localparam int unsigned MDEN_W     = 17;
	localparam int unsigned MQ_W       = 35;

	typedef struct packed {
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] first_vel_x;
		logic signed [31:0] first_vel_y;
		logic signed [31:0] second_vel_x;
		logic signed [31:0] second_vel_y;
		logic [15:0]        first_mass;
		logic [15:0]        second_mass;
		logic               last_pair;
	} ecd_req_t;

	typedef struct packed {
		logic signed [31:0] new_first_vel_x;
		logic signed [31:0] new_first_vel_y;
		logic signed [31:0] new_second_vel_x;
		logic signed [31:0] new_second_vel_y;
		logic               coincident_flag;
		logic               saturated_flag;
		logic               last_pair_done;
	} ecd_res_t;

endpackage

FILE: rtl/ecd_div.sv
// Pipelined restoring divider: one quotient bit per stage, with a side tag.
// Assumes num < den * 2^Q_W. Uses ecd_pkg for default widths.
module ecd_div #(
	parameter int unsigned NUM_W = ecd_pkg::NNUM_W,
	parameter int unsigned DEN_W = ecd_pkg::NDEN_W,
	parameter int unsigned Q_W   = ecd_pkg::NQ_W,
	parameter int unsigned TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_vld,
	output logic [Q_W-1:0]   out_quo,
	output logic [TAG_W-1:0] out_tag
);

	logic             vld_s [Q_W];
	logic [DEN_W-1:0] rem_s [Q_W];
	logic [Q_W-1:0]   qn_s  [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [TAG_W-1:0] tag_s [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic             v_in;
		logic [DEN_W-1:0] r_in;
		logic [DEN_W-1:0] d_in;
		logic [Q_W-1:0]   q_in;
		logic [TAG_W-1:0] t_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		// low numerator bits shift out the top of qn while quotient bits enter below
		if (k == 0) begin : g_first
			assign v_in = in_vld;
			assign r_in = DEN_W'(in_num >> Q_W);
			assign q_in = in_num[Q_W-1:0];
			assign d_in = in_den;
			assign t_in = in_tag;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = qn_s[k-1];
			assign d_in = den_s[k-1];
			assign t_in = tag_s[k-1];
		end

		assign trial = {r_in, q_in[Q_W-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else         vld_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
			qn_s[k]  <= {q_in[Q_W-2:0], ge};
			den_s[k] <= d_in;
			tag_s[k] <= t_in;
		end
	end

	assign out_vld = vld_s[Q_W-1];
	assign out_quo = qn_s[Q_W-1];
	assign out_tag = tag_s[Q_W-1];

endmodule

FILE: rtl/elastic_collision_two_discs_core.sv
// Two-disc elastic collision core: top level. Uses ecd_pkg and ecd_div.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth comes from the 32-stage square root, the 29-stage normal divider and the
// 35-stage momentum divider. Reset clears only the valid bits; done carries no backpressure.
module elastic_collision_two_discs_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ecd_pkg::ecd_req_t req,
	output logic             done,
	output ecd_pkg::ecd_res_t res
);
	import ecd_pkg::*;

	localparam int unsigned NTOP = 30; // normalized magnitude lies in [2^30, 2^31)

	typedef struct packed {
		logic signed [31:0] v1x;
		logic signed [31:0] v1y;
		logic signed [31:0] v2x;
		logic signed [31:0] v2y;
		logic [15:0]        ma;
		logic [15:0]        mb;
		logic               last;
		logic               coin;
		logic               sx;
		logic               sy;
	} side_t;

	typedef struct packed {
		side_t              sd;
		logic signed [29:0] nx;
		logic signed [29:0] ny;
		logic signed [33:0] t1;
		logic signed [33:0] t2;
		logic               neg1;
	} mtag_t;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
		logic signed [63:0] h;
		h = x + (64'sd1 <<< (NORM_BITS - 1));
		return h >>> NORM_BITS;
	endfunction

	assign busy = 1'b0;

	// S1: centre difference, magnitudes, coincidence
	logic signed [32:0] dx, dy;
	logic [32:0]        adx, ady;
	side_t              side_in;
	logic               vld_s1;
	logic [32:0]        ax_s1, ay_s1;
	side_t              side_s1;

	always_comb begin
		dx           = {req.second_pos_x[31], req.second_pos_x} - {req.first_pos_x[31], req.first_pos_x};
		dy           = {req.second_pos_y[31], req.second_pos_y} - {req.first_pos_y[31], req.first_pos_y};
		adx          = dx[32] ? -dx : dx;
		ady          = dy[32] ? -dy : dy;
		side_in.v1x  = req.first_vel_x;
		side_in.v1y  = req.first_vel_y;
		side_in.v2x  = req.second_vel_x;
		side_in.v2y  = req.second_vel_y;
		side_in.ma   = req.first_mass;
		side_in.mb   = req.second_mass;
		side_in.last = req.last_pair;
		side_in.coin = (dx == '0) && (dy == '0);
		side_in.sx   = dx[32];
		side_in.sy   = dy[32];
	end

	// S2: leading bit of the larger magnitude and the shift to normalize
	logic [32:0] mag_or;
	logic [5:0]  msb;
	logic [4:0]  lsh;
	logic [1:0]  rsh;
	logic        vld_s2;
	logic [32:0] ax_s2, ay_s2;
	logic [4:0]  lsh_s2;
	logic [1:0]  rsh_s2;
	side_t       side_s2;

	always_comb begin
		mag_or = ax_s1 | ay_s1;
		msb    = '0;
		for (int i = 0; i < 33; i++) begin
			if (mag_or[i]) msb = 6'(i);
		end
		if (msb > 6'(NTOP)) begin
			rsh = 2'(msb - 6'(NTOP));
			lsh = '0;
		end else begin
			rsh = '0;
			lsh = 5'(6'(NTOP) - msb);
		end
	end

	// S3: apply the shift (right shift truncates)
	logic [32:0] shx, shy;
	logic        vld_s3;
	logic [30:0] ax_s3, ay_s3;
	side_t       side_s3;

	always_comb begin
		shx = (ax_s2 >> rsh_s2) << lsh_s2;
		shy = (ay_s2 >> rsh_s2) << lsh_s2;
	end

	// S4: squares, S5: sum of squares
	logic        vld_s4, vld_s5;
	logic [61:0] sqx_s4, sqy_s4;
	logic [62:0] sum_s5;
	logic [30:0] ax_s4, ay_s4, ax_s5, ay_s5;
	side_t       side_s4, side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1   <= adx;
		ay_s1   <= ady;
		side_s1 <= side_in;
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		lsh_s2  <= lsh;
		rsh_s2  <= rsh;
		side_s2 <= side_s1;
		ax_s3   <= shx[30:0];
		ay_s3   <= shy[30:0];
		side_s3 <= side_s2;
		sqx_s4  <= ax_s3 * ax_s3;
		sqy_s4  <= ay_s3 * ay_s3;
		ax_s4   <= ax_s3;
		ay_s4   <= ay_s3;
		side_s4 <= side_s3;
		sum_s5  <= 63'(sqx_s4) + 63'(sqy_s4);
		ax_s5   <= ax_s4;
		ay_s5   <= ay_s4;
		side_s5 <= side_s4;
	end

	// square root: digit by digit, one root bit per stage
	logic        sq_vld_s  [SQRT_STEPS];
	logic [34:0] sq_rem_s  [SQRT_STEPS];
	logic [31:0] sq_root_s [SQRT_STEPS];
	logic [63:0] sq_v_s    [SQRT_STEPS];
	logic [30:0] sq_ax_s   [SQRT_STEPS];
	logic [30:0] sq_ay_s   [SQRT_STEPS];
	side_t       sq_side_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic        v_in;
		logic [34:0] r_in;
		logic [31:0] q_in;
		logic [63:0] x_in;
		logic [30:0] ax_in, ay_in;
		side_t       sd_in;
		logic [34:0] shf, trial;
		logic        ge;

		if (k == 0) begin : g_first
			assign v_in  = vld_s5;
			assign r_in  = '0;
			assign q_in  = '0;
			assign x_in  = {1'b0, sum_s5};
			assign ax_in = ax_s5;
			assign ay_in = ay_s5;
			assign sd_in = side_s5;
		end else begin : g_next
			assign v_in  = sq_vld_s[k-1];
			assign r_in  = sq_rem_s[k-1];
			assign q_in  = sq_root_s[k-1];
			assign x_in  = sq_v_s[k-1];
			assign ax_in = sq_ax_s[k-1];
			assign ay_in = sq_ay_s[k-1];
			assign sd_in = sq_side_s[k-1];
		end

		assign shf   = {r_in[32:0], x_in[63:62]};
		assign trial = {1'b0, q_in, 2'b01};
		assign ge    = shf >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k] <= 1'b0;
			else         sq_vld_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k]  <= ge ? shf - trial : shf;
			sq_root_s[k] <= {q_in[30:0], ge};
			sq_v_s[k]    <= {x_in[61:0], 2'b00};
			sq_ax_s[k]   <= ax_in;
			sq_ay_s[k]   <= ay_in;
			sq_side_s[k] <= sd_in;
		end
	end

	// S6: normal numerators with half-divisor rounding
	logic              vld_s6;
	logic [NNUM_W-1:0] numx_s6, numy_s6;
	logic [31:0]       len_s6;
	side_t             side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= sq_vld_s[SQRT_STEPS-1];
	end

	always_ff @(posedge clk) begin
		numx_s6 <= {1'b0, sq_ax_s[SQRT_STEPS-1], {NORM_BITS{1'b0}}}
			+ NNUM_W'(sq_root_s[SQRT_STEPS-1] >> 1);
		numy_s6 <= {1'b0, sq_ay_s[SQRT_STEPS-1], {NORM_BITS{1'b0}}}
			+ NNUM_W'(sq_root_s[SQRT_STEPS-1] >> 1);
		len_s6  <= sq_root_s[SQRT_STEPS-1];
		side_s6 <= sq_side_s[SQRT_STEPS-1];
	end

	// normal dividers, x and y lanes in lockstep
	logic                     nd_vld_a, nd_vld_b;
	logic [NQ_W-1:0]          nd_q_a, nd_q_b;
	logic [$bits(side_t)-1:0] nd_tag_a;
	logic                     nd_sy;
	side_t                    nd_side;

	ecd_div #(
		.NUM_W(NNUM_W), .DEN_W(NDEN_W), .Q_W(NQ_W), .TAG_W($bits(side_t))
	) u_ndiv_x (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s6), .in_num(numx_s6), .in_den(len_s6),
		.in_tag(side_s6), .out_vld(nd_vld_a), .out_quo(nd_q_a), .out_tag(nd_tag_a)
	);

	ecd_div #(
		.NUM_W(NNUM_W), .DEN_W(NDEN_W), .Q_W(NQ_W), .TAG_W(1)
	) u_ndiv_y (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s6), .in_num(numy_s6), .in_den(len_s6),
		.in_tag(side_s6.sy), .out_vld(nd_vld_b), .out_quo(nd_q_b), .out_tag(nd_sy)
	);

	assign nd_side = nd_tag_a;

	// S7: signed normal, S8: velocity by normal products, S9: rounded dot products
	logic               vld_s7, vld_s8, vld_s9;
	logic signed [29:0] nx_s7, ny_s7, nx_s8, ny_s8, nx_s9, ny_s9;
	side_t              side_s7, side_s8, side_s9;
	logic signed [61:0] pa1_s8, pb1_s8, pc1_s8, pd1_s8;
	logic signed [61:0] pa2_s8, pb2_s8, pc2_s8, pd2_s8;
	logic signed [63:0] r_t1, r_t2, r_a1, r_a2;
	logic signed [33:0] t1_s9, t2_s9, a1_s9, a2_s9;

	always_comb begin
		r_t1 = rnd(64'(pc1_s8) - 64'(pd1_s8));
		r_t2 = rnd(64'(pc2_s8) - 64'(pd2_s8));
		r_a1 = rnd(64'(pa1_s8) + 64'(pb1_s8));
		r_a2 = rnd(64'(pa2_s8) + 64'(pb2_s8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s7 <= nd_vld_a;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		nx_s7   <= nd_side.sx ? -$signed({1'b0, nd_q_a}) : $signed({1'b0, nd_q_a});
		ny_s7   <= nd_sy ? -$signed({1'b0, nd_q_b}) : $signed({1'b0, nd_q_b});
		side_s7 <= nd_side;
		// tangent is (-ny, nx)
		pa1_s8  <= side_s7.v1x * nx_s7;
		pb1_s8  <= side_s7.v1y * ny_s7;
		pc1_s8  <= side_s7.v1y * nx_s7;
		pd1_s8  <= side_s7.v1x * ny_s7;
		pa2_s8  <= side_s7.v2x * nx_s7;
		pb2_s8  <= side_s7.v2y * ny_s7;
		pc2_s8  <= side_s7.v2y * nx_s7;
		pd2_s8  <= side_s7.v2x * ny_s7;
		nx_s8   <= nx_s7;
		ny_s8   <= ny_s7;
		side_s8 <= side_s7;
		t1_s9   <= r_t1[33:0];
		t2_s9   <= r_t2[33:0];
		a1_s9   <= r_a1[33:0];
		a2_s9   <= r_a2[33:0];
		nx_s9   <= nx_s8;
		ny_s9   <= ny_s8;
		side_s9 <= side_s8;
	end

	// S10: momentum products; two zero masses count as equal masses
	logic [15:0]        ma_e, mb_e;
	logic signed [16:0] dm, ndm;
	logic               vld_s10, vld_s11;
	logic signed [51:0] q1_s10, q2_s10, q3_s10, q4_s10;
	logic [MDEN_W-1:0]  den_s10, den_s11;
	logic signed [29:0] nx_s10, ny_s10;
	logic signed [33:0] t1_s10, t2_s10;
	side_t              side_s10;

	always_comb begin
		if (side_s9.ma == '0 && side_s9.mb == '0) begin
			ma_e = 16'd1;
			mb_e = 16'd1;
		end else begin
			ma_e = side_s9.ma;
			mb_e = side_s9.mb;
		end
		dm  = $signed({1'b0, ma_e}) - $signed({1'b0, mb_e});
		ndm = -dm;
	end

	// S11: numerator magnitude plus half the mass sum
	logic signed [52:0] n1, n2;
	logic [52:0]        an1, an2;
	logic [MNUM_W-1:0]  num1_s11, num2_s11;
	logic               neg2_s11;
	mtag_t              mtag_s11;

	always_comb begin
		n1  = 53'(q1_s10) + 53'(q2_s10);
		n2  = 53'(q3_s10) + 53'(q4_s10);
		an1 = n1[52] ? -n1 : n1;
		an2 = n2[52] ? -n2 : n2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		q1_s10        <= a1_s9 * dm;
		q2_s10        <= a2_s9 * $signed({1'b0, mb_e, 1'b0});
		q3_s10        <= a2_s9 * ndm;
		q4_s10        <= a1_s9 * $signed({1'b0, ma_e, 1'b0});
		den_s10       <= MDEN_W'(ma_e) + MDEN_W'(mb_e);
		nx_s10        <= nx_s9;
		ny_s10        <= ny_s9;
		t1_s10        <= t1_s9;
		t2_s10        <= t2_s9;
		side_s10      <= side_s9;
		num1_s11      <= MNUM_W'(an1) + MNUM_W'(den_s10 >> 1);
		num2_s11      <= MNUM_W'(an2) + MNUM_W'(den_s10 >> 1);
		den_s11       <= den_s10;
		neg2_s11      <= n2[52];
		mtag_s11.sd   <= side_s10;
		mtag_s11.nx   <= nx_s10;
		mtag_s11.ny   <= ny_s10;
		mtag_s11.t1   <= t1_s10;
		mtag_s11.t2   <= t2_s10;
		mtag_s11.neg1 <= n1[52];
	end

	// momentum dividers, first and second disc in lockstep
	logic                     md_vld_a, md_vld_b;
	logic [MQ_W-1:0]          md_q_a, md_q_b;
	logic [$bits(mtag_t)-1:0] md_tag_a;
	logic                     md_neg2;
	mtag_t                    md_tag;

	ecd_div #(
		.NUM_W(MNUM_W), .DEN_W(MDEN_W), .Q_W(MQ_W), .TAG_W($bits(mtag_t))
	) u_mdiv_1 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s11), .in_num(num1_s11), .in_den(den_s11),
		.in_tag(mtag_s11), .out_vld(md_vld_a), .out_quo(md_q_a), .out_tag(md_tag_a)
	);

	ecd_div #(
		.NUM_W(MNUM_W), .DEN_W(MDEN_W), .Q_W(MQ_W), .TAG_W(1)
	) u_mdiv_2 (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s11), .in_num(num2_s11), .in_den(den_s11),
		.in_tag(neg2_s11), .out_vld(md_vld_b), .out_quo(md_q_b), .out_tag(md_neg2)
	);

	assign md_tag = md_tag_a;

	// S12: signed normal velocities, S13: rebuild products
	logic               vld_s12, vld_s13;
	logic signed [35:0] m1_s12, m2_s12;
	mtag_t              mtag_s12;
	logic signed [63:0] xa1_s13, xb1_s13, ya1_s13, yb1_s13;
	logic signed [63:0] xa2_s13, xb2_s13, ya2_s13, yb2_s13;
	side_t              side_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s12 <= md_vld_a;
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		m1_s12   <= md_tag.neg1 ? -$signed({1'b0, md_q_a}) : $signed({1'b0, md_q_a});
		m2_s12   <= md_neg2 ? -$signed({1'b0, md_q_b}) : $signed({1'b0, md_q_b});
		mtag_s12 <= md_tag;
		xa1_s13  <= mtag_s12.nx * m1_s12;
		xb1_s13  <= mtag_s12.ny * mtag_s12.t1;
		ya1_s13  <= mtag_s12.nx * mtag_s12.t1;
		yb1_s13  <= mtag_s12.ny * m1_s12;
		xa2_s13  <= mtag_s12.nx * m2_s12;
		xb2_s13  <= mtag_s12.ny * mtag_s12.t2;
		ya2_s13  <= mtag_s12.nx * mtag_s12.t2;
		yb2_s13  <= mtag_s12.ny * m2_s12;
		side_s13 <= mtag_s12.sd;
	end

	// S14: sum, round, clip, coincident pass-through; this is the result register
	logic signed [63:0] sum_w [4];
	logic signed [63:0] rnd_w;
	logic [31:0]        clp_w [4];
	logic [3:0]         sat_w;
	logic               vld_s14;
	ecd_res_t           res_s14;

	always_comb begin
		sum_w[0] = xa1_s13 - xb1_s13;
		sum_w[1] = ya1_s13 + yb1_s13;
		sum_w[2] = xa2_s13 - xb2_s13;
		sum_w[3] = ya2_s13 + yb2_s13;
		rnd_w    = '0;
		for (int i = 0; i < 4; i++) begin
			rnd_w = rnd(sum_w[i]);
			if (rnd_w > 64'sd2147483647) begin
				clp_w[i] = 32'h7FFF_FFFF;
				sat_w[i] = 1'b1;
			end else if (rnd_w < -64'sd2147483648) begin
				clp_w[i] = 32'h8000_0000;
				sat_w[i] = 1'b1;
			end else begin
				clp_w[i] = rnd_w[31:0];
				sat_w[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s14 <= 1'b0;
		else         vld_s14 <= vld_s13;
	end

	always_ff @(posedge clk) begin
		res_s14.last_pair_done <= side_s13.last;
		if (side_s13.coin) begin
			res_s14.new_first_vel_x  <= side_s13.v1x;
			res_s14.new_first_vel_y  <= side_s13.v1y;
			res_s14.new_second_vel_x <= side_s13.v2x;
			res_s14.new_second_vel_y <= side_s13.v2y;
			res_s14.coincident_flag  <= 1'b1;
			res_s14.saturated_flag   <= 1'b0;
		end else begin
			res_s14.new_first_vel_x  <= clp_w[0];
			res_s14.new_first_vel_y  <= clp_w[1];
			res_s14.new_second_vel_x <= clp_w[2];
			res_s14.new_second_vel_y <= clp_w[3];
			res_s14.coincident_flag  <= 1'b0;
			res_s14.saturated_flag   <= |sat_w;
		end
	end

	assign done = vld_s14;
	assign res  = res_s14;

	// checks
	a_ndiv_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		nd_vld_a == nd_vld_b)
		else $error("normal divider lanes out of step");

	a_mdiv_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		md_vld_a == md_vld_b)
		else $error("momentum divider lanes out of step");

	a_unit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && !side_s7.coin |->
		(nx_s7 <= $signed(30'(1 << NORM_BITS))) && (nx_s7 >= -$signed(30'(1 << NORM_BITS)))
		&& (ny_s7 <= $signed(30'(1 << NORM_BITS))) && (ny_s7 >= -$signed(30'(1 << NORM_BITS))))
		else $error("normal component exceeds unit length");

	a_coin_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.coincident_flag |-> !res.saturated_flag)
		else $error("coincident result marked saturated");

endmodule

FILE: tb/tb.sv
// Testbench for elastic_collision_two_discs_core: directed and random collision requests.
// Predicts each result with an independent fixed-point collision model; uses ecd_pkg.
// Driver and monitor are clocked always blocks; a watchdog bounds the run.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ecd_pkg::*;

	localparam int LATENCY = 110;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ecd_req_t req;
	logic done;
	ecd_res_t res;

	ecd_req_t pending_reqs[$];
	ecd_res_t expected_vels[$];
	int errors;
	int idle_cycles;
	int gap_left;
	bit stim_done;
	bit drain_pause;
	int pause_at;
	int sent;

	elastic_collision_two_discs_core u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.res   (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor((x + 2^27) / 2^28), x wide signed
	function automatic logic signed [127:0] norm_round(input logic signed [127:0] x);
		return (x + (128'sd1 <<< (NORM_BITS - 1))) >>> NORM_BITS;
	endfunction

	// rounded quotient, ties away from zero
	function automatic logic signed [127:0] div_nearest(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic [127:0] mag;
		logic [127:0] q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, ref bit sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// expected post-collision velocities for one request
	function automatic ecd_res_t collide(input ecd_req_t r);
		ecd_res_t o;
		logic signed [127:0] dx, dy, nx, ny, tx, ty, t1, t2, a1, a2, ma, mb, sm, m1, m2;
		logic signed [127:0] v1x, v1y, v2x, v2y;
		logic [63:0] ax, ay, len;
		bit sat;
		sat = 1'b0;
		dx = 128'(r.second_pos_x) - 128'(r.first_pos_x);
		dy = 128'(r.second_pos_y) - 128'(r.first_pos_y);
		v1x = r.first_vel_x; v1y = r.first_vel_y;
		v2x = r.second_vel_x; v2y = r.second_vel_y;
		o = '0;
		o.last_pair_done = r.last_pair;
		if (dx == 0 && dy == 0) begin
			o.new_first_vel_x = r.first_vel_x;
			o.new_first_vel_y = r.first_vel_y;
			o.new_second_vel_x = r.second_vel_x;
			o.new_second_vel_y = r.second_vel_y;
			o.coincident_flag = 1'b1;
			return o;
		end
		ax = dx < 0 ? 64'(-dx) : 64'(dx);
		ay = dy < 0 ? 64'(-dy) : 64'(dy);
		// normalize the larger magnitude into [2^30, 2^31)
		while ((ax > ay ? ax : ay) >= (64'd1 << 31)) begin
			ax = ax >> 1;
			ay = ay >> 1;
		end
		while ((ax > ay ? ax : ay) < (64'd1 << 30)) begin
			ax = ax << 1;
			ay = ay << 1;
		end
		len = int_sqrt(ax * ax + ay * ay);
		nx = $signed({64'd0, ((ax << NORM_BITS) + len / 2) / len});
		ny = $signed({64'd0, ((ay << NORM_BITS) + len / 2) / len});
		if (dx < 0) nx = -nx;
		if (dy < 0) ny = -ny;
		tx = -ny;
		ty = nx;
		t1 = norm_round(v1x * tx + v1y * ty);
		t2 = norm_round(v2x * tx + v2y * ty);
		a1 = norm_round(v1x * nx + v1y * ny);
		a2 = norm_round(v2x * nx + v2y * ny);
		ma = r.first_mass;
		mb = r.second_mass;
		if (ma + mb == 0) begin
			ma = 1;
			mb = 1;
		end
		sm = ma + mb;
		m1 = div_nearest(a1 * (ma - mb) + 2 * mb * a2, sm);
		m2 = div_nearest(a2 * (mb - ma) + 2 * ma * a1, sm);
		o.new_first_vel_x = clamp32(norm_round(tx * t1 + nx * m1), sat);
		o.new_first_vel_y = clamp32(norm_round(ty * t1 + ny * m1), sat);
		o.new_second_vel_x = clamp32(norm_round(tx * t2 + nx * m2), sat);
		o.new_second_vel_y = clamp32(norm_round(ty * t2 + ny * m2), sat);
		o.saturated_flag = sat;
		return o;
	endfunction

	function automatic logic [31:0] rand_word(input int kind);
		case (kind)
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
		endcase
	endfunction

	function automatic logic [15:0] rand_mass();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'hffff : 16'h0001;
			1: return 16'($urandom());
			default: return 16'($urandom_range(1, 16'h0400));
		endcase
	endfunction

	function automatic ecd_req_t rand_pair();
		ecd_req_t r;
		int k;
		k = $urandom_range(0, 9);
		r.first_pos_x = rand_word(k < 3 ? 0 : 3);
		r.first_pos_y = rand_word(k < 3 ? 0 : 3);
		// close neighbors exercise small separations
		if (k == 9) begin
			r.second_pos_x = r.first_pos_x + rand_word(2);
			r.second_pos_y = r.first_pos_y + rand_word(2);
		end else begin
			r.second_pos_x = rand_word(k < 3 ? 0 : 3);
			r.second_pos_y = rand_word(k < 3 ? 0 : 3);
		end
		if (k == 8) begin
			r.second_pos_x = r.first_pos_x;
			r.second_pos_y = r.first_pos_y;
		end
		r.first_vel_x = rand_word(k % 4);
		r.first_vel_y = rand_word(k % 4);
		r.second_vel_x = rand_word((k + 1) % 4);
		r.second_vel_y = rand_word((k + 2) % 4);
		r.first_mass = rand_mass();
		r.second_mass = rand_mass();
		r.last_pair = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// directed requests, then random ones
	initial begin
		ecd_req_t r;
		r = '0;
		r.second_pos_x = 32'sh00010000;
		r.first_vel_x = 32'sh00010000;
		r.first_mass = 16'h0100;
		r.second_mass = 16'h0100;
		pending_reqs = {pending_reqs, r};   // head-on, equal masses
		r.last_pair = 1'b1;
		r.second_mass = 16'hffff;
		r.first_mass = 16'h0001;
		pending_reqs = {pending_reqs, r};   // light disc on heavy disc
		r.first_mass = 16'hffff;
		r.second_mass = 16'h0001;
		pending_reqs = {pending_reqs, r};
		r.second_pos_x = 32'sh00000000;
		pending_reqs = {pending_reqs, r};   // coincident centers
		r.first_pos_x = 32'sh80000000;
		r.second_pos_x = 32'sh7fffffff;
		r.first_pos_y = 32'sh7fffffff;
		r.second_pos_y = 32'sh80000000;
		pending_reqs = {pending_reqs, r};   // widest separation
		r.first_vel_x = 32'sh7fffffff;
		r.first_vel_y = 32'sh80000000;
		r.second_vel_x = 32'sh80000000;
		r.second_vel_y = 32'sh7fffffff;
		pending_reqs = {pending_reqs, r};   // huge velocities, saturation
		r.first_pos_x = 0; r.first_pos_y = 0;
		r.second_pos_x = 1; r.second_pos_y = -1;
		pending_reqs = {pending_reqs, r};   // tiny diagonal separation
		r.second_pos_x = -1; r.second_pos_y = 0;
		r.first_vel_x = 32'sh80000000; r.first_vel_y = 32'sh80000000;
		pending_reqs = {pending_reqs, r};
		r.second_pos_x = 0; r.second_pos_y = 32'sh7fffffff;
		r.first_mass = 16'h0001; r.second_mass = 16'h0001;
		r.last_pair = 1'b0;
		pending_reqs = {pending_reqs, r};
		r.first_vel_x = -1; r.first_vel_y = -1; r.second_vel_x = -1; r.second_vel_y = -1;
		r.first_pos_x = 32'shffffffff; r.first_pos_y = 32'shffffffff;
		r.second_pos_x = 0; r.second_pos_y = 0;
		pending_reqs = {pending_reqs, r};
		for (int i = 0; i < 1500; i++) pending_reqs = {pending_reqs, rand_pair()};
		pause_at = $urandom_range(200, 1200);
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left <= 0;
			sent <= 0;
			stim_done <= 1'b0;
			drain_pause <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_vels = {expected_vels, collide(req)};
				sent <= sent + 1;
			end
			if (start && busy) begin
				// hold the request until taken
			end else if (sent >= pause_at && !drain_pause) begin
				// hold off until every outstanding result is back
				start <= 1'b0;
				if (!start && expected_vels.size() == 0) drain_pause <= 1'b1;
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				start <= 1'b1;
				req <= pending_reqs.pop_front();
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			end else begin
				start <= 1'b0;
				if (!start) stim_done <= 1'b1;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		ecd_res_t exp_res;
		if (arst_n && done) begin
			if (expected_vels.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res);
				errors++;
			end else begin
				exp_res = expected_vels.pop_front();
				if (res.new_first_vel_x !== exp_res.new_first_vel_x)
					$display("%0t: new_first_vel_x exp %h got %h", $time,
						exp_res.new_first_vel_x, res.new_first_vel_x);
				if (res.new_first_vel_y !== exp_res.new_first_vel_y)
					$display("%0t: new_first_vel_y exp %h got %h", $time,
						exp_res.new_first_vel_y, res.new_first_vel_y);
				if (res.new_second_vel_x !== exp_res.new_second_vel_x)
					$display("%0t: new_second_vel_x exp %h got %h", $time,
						exp_res.new_second_vel_x, res.new_second_vel_x);
				if (res.new_second_vel_y !== exp_res.new_second_vel_y)
					$display("%0t: new_second_vel_y exp %h got %h", $time,
						exp_res.new_second_vel_y, res.new_second_vel_y);
				if (res.coincident_flag !== exp_res.coincident_flag)
					$display("%0t: coincident_flag exp %b got %b", $time,
						exp_res.coincident_flag, res.coincident_flag);
				if (res.saturated_flag !== exp_res.saturated_flag)
					$display("%0t: saturated_flag exp %b got %b", $time,
						exp_res.saturated_flag, res.saturated_flag);
				if (res.last_pair_done !== exp_res.last_pair_done)
					$display("%0t: last_pair_done exp %b got %b", $time,
						exp_res.last_pair_done, res.last_pair_done);
				if (res !== exp_res) errors++;
			end
		end
	end

	// watchdog: cycles with no request or result taken
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (!(stim_done && expected_vels.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
		end else begin
			repeat (LATENCY + 20) @(posedge clk);
			if (errors == 0 && expected_vels.size() == 0) $display("ALL CHECKS PASSED");
			else $display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/ecd_pkg.sv
rtl/ecd_div.sv
rtl/elastic_collision_two_discs_core.sv
tb/tb.sv
